// ----- rtl/esd_pkg.sv -----
package esd_pkg;

	localparam logic [11:0] LENGTH_CAP = 12'd4095;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_EOF_BODY   = 3'd0;
	localparam logic [2:0] ERR_EOF_ESCAPE = 3'd1;
	localparam logic [2:0] ERR_EOF_HEX    = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
	localparam logic [2:0] ERR_UNKNOWN    = 3'd4;
	localparam logic [2:0] ERR_TOO_LONG   = 3'd5;

	localparam logic REG_DELIMITER    = 1'b0;
	localparam logic REG_LENGTH_LIMIT = 1'b1;

	localparam logic [6:0]  DELIMITER_RESET    = 7'd34;
	localparam logic [11:0] LENGTH_LIMIT_RESET = 12'd4095;

	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_X         = 8'h78;

	typedef enum logic [3:0] {
		MODE_BODY = 4'b0001,
		MODE_ESC  = 4'b0010,
		MODE_HEX1 = 4'b0100,
		MODE_HEX2 = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} esd_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_value;
		logic [2:0]  error_code;
		logic [11:0] literal_length;
	} esd_out_t;

	typedef struct packed {
		mode_t       mode;
		logic [3:0]  hex_high_nibble;
		logic [11:0] char_count;
	} esd_state_t;

	typedef struct packed {
		logic [6:0]  delimiter;
		logic [11:0] length_limit;
	} esd_cfg_t;

	// {legal, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end
		return r;
	endfunction

	// {known, control code}
	function automatic logic [8:0] escape_code(input logic [7:0] b);
		logic [8:0] r;
		unique case (b)
			8'h30: r = {1'b1, 8'h00};
			8'h61: r = {1'b1, 8'h07};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			8'h6E: r = {1'b1, 8'h0A};
			8'h72: r = {1'b1, 8'h0D};
			8'h74: r = {1'b1, 8'h09};
			8'h76: r = {1'b1, 8'h0B};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/esd_step.sv -----
module esd_step (
	input  esd_pkg::esd_state_t state,
	input  esd_pkg::esd_cfg_t   cfg,
	input  esd_pkg::esd_in_t    item,
	output esd_pkg::esd_state_t next_state,
	output logic                has_result,
	output esd_pkg::esd_out_t   result
);
	import esd_pkg::*;

	logic [11:0] limit;
	logic [7:0]  delim_byte;
	logic [4:0]  hex;
	logic [8:0]  esc;

	assign limit      = (LENGTH_CAP < cfg.length_limit) ? LENGTH_CAP : cfg.length_limit;
	assign delim_byte = {1'b0, cfg.delimiter};
	assign hex        = hex_value(item.in_byte);
	assign esc        = escape_code(item.in_byte);

	always_comb begin
		logic       emit_req;
		logic [7:0] emit_char;
		logic       fail_req;
		logic [2:0] fail_code;
		emit_req   = 1'b0;
		emit_char  = 8'd0;
		fail_req   = 1'b0;
		fail_code  = ERR_EOF_BODY;
		next_state = state;
		has_result = 1'b0;
		result     = '0;

		if (item.end_of_input) begin
			fail_req = 1'b1;
			unique case (state.mode)
				MODE_BODY: fail_code = ERR_EOF_BODY;
				MODE_ESC:  fail_code = ERR_EOF_ESCAPE;
				default:   fail_code = ERR_EOF_HEX;
			endcase
		end else begin
			unique case (state.mode)
				MODE_BODY: begin
					priority if (item.in_byte == delim_byte) begin
						has_result            = 1'b1;
						result.kind           = KIND_END;
						result.literal_length = state.char_count;
						next_state.mode            = MODE_BODY;
						next_state.hex_high_nibble = 4'd0;
						next_state.char_count      = 12'd0;
					end else if (item.in_byte == CHAR_BACKSLASH) begin
						next_state.mode = MODE_ESC;
					end else begin
						emit_req  = 1'b1;
						emit_char = item.in_byte;
					end
				end
				MODE_ESC: begin
					priority if (item.in_byte == CHAR_X) begin
						next_state.mode = MODE_HEX1;
					end else if (item.in_byte == CHAR_BACKSLASH
						|| item.in_byte == delim_byte) begin
						emit_req  = 1'b1;
						emit_char = item.in_byte;
					end else if (esc[8]) begin
						emit_req  = 1'b1;
						emit_char = esc[7:0];
					end else begin
						fail_req  = 1'b1;
						fail_code = ERR_UNKNOWN;
					end
				end
				MODE_HEX1: begin
					if (hex[4]) begin
						next_state.hex_high_nibble = hex[3:0];
						next_state.mode            = MODE_HEX2;
					end else begin
						fail_req  = 1'b1;
						fail_code = ERR_BAD_HEX;
					end
				end
				default: begin
					if (hex[4]) begin
						emit_req  = 1'b1;
						emit_char = {state.hex_high_nibble, hex[3:0]};
					end else begin
						fail_req  = 1'b1;
						fail_code = ERR_BAD_HEX;
					end
				end
			endcase
		end

		// a character past the limit turns into a too-long error
		if (emit_req) begin
			if (state.char_count >= limit) begin
				fail_req  = 1'b1;
				fail_code = ERR_TOO_LONG;
			end else begin
				has_result            = 1'b1;
				result.kind           = KIND_CHAR;
				result.char_value     = emit_char;
				next_state.char_count = state.char_count + 12'd1;
				next_state.mode       = MODE_BODY;
			end
		end

		if (fail_req) begin
			has_result                 = 1'b1;
			result                     = '0;
			result.kind                = KIND_ERR;
			result.error_code          = fail_code;
			next_state.mode            = MODE_BODY;
			next_state.hex_high_nibble = 4'd0;
			next_state.char_count      = 12'd0;
		end
	end

endmodule

// ----- rtl/escaped_string_decoder_core.sv -----
// Escaped string decoder core.
// Feed the raw bytes of a string literal body, after its opening delimiter,
// on the in channel (valid/ready), one byte per item; set end_of_input to
// mark the end of the stream. Each item yields at most one result item on
// the out channel: a decoded character, the end of the literal with its
// length, or an error. Backslashes, the x of a hex escape and the first hex
// digit yield nothing.
// An item is registered in the input register on acceptance and decoded
// from there into the output register; an item with a result waits while
// the output register holds an untaken result. One item per cycle is
// sustained while the receiver takes results; the rate is set by the
// single decode step between the input register and the output register,
// which also updates the mode, hex nibble and character count.
// While the receiver stalls, the output register holds its item; silent
// items keep flowing, and the input side stops once the held item has a
// result of its own waiting behind the stalled one.
// Reset clears both channels, puts the decoder in the body state with a
// zero count, and sets the delimiter to '"' and the length limit to 4095.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
module escaped_string_decoder_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [11:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  esd_pkg::esd_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output esd_pkg::esd_out_t out_item
);
	import esd_pkg::*;

	esd_cfg_t   cfg_q;
	esd_state_t state_q;
	esd_state_t next_state;
	esd_in_t    item_s1;
	logic       valid_s1;
	logic       has_result;
	esd_out_t   result;
	logic       advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter    <= DELIMITER_RESET;
			cfg_q.length_limit <= LENGTH_LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DELIMITER:    cfg_q.delimiter    <= cfg_data[6:0];
				REG_LENGTH_LIMIT: cfg_q.length_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	esd_step u_step (
		.state      (state_q),
		.cfg        (cfg_q),
		.item       (item_s1),
		.next_state (next_state),
		.has_result (has_result),
		.result     (result)
	);

	// silent items may pass a stalled result
	assign advance  = valid_s1 && (!out_valid || out_ready || !has_result);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode            <= MODE_BODY;
			state_q.hex_high_nibble <= 4'd0;
			state_q.char_count      <= 12'd0;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && has_result) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_item <= result;
		end
	end

	a_ready_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled without a held result");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_result && (result.kind == KIND_END || result.kind == KIND_ERR)
		|=> state_q.mode == MODE_BODY && state_q.char_count == 12'd0)
		else $error("decoder did not restart after end or error");

	a_silent_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !has_result |=> $stable(state_q.char_count))
		else $error("silent item changed the character count");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.kind == KIND_CHAR || out_item.kind == KIND_END
		|| out_item.kind == KIND_ERR)
		else $error("result item with an undefined kind");

endmodule

// ----- tb/escaped_string_decoder_core_tb.sv -----
module escaped_string_decoder_core_tb;
	import esd_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam logic [63:0] ESC_LETTERS = "0abfnrtv";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = REG_DELIMITER;
	logic [11:0] cfg_data = 12'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	esd_in_t     in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	esd_out_t    out_item;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int items_sent = 0;

	esd_out_t predicted_outputs[$];

	// decoder state and registers as the block should hold them
	mode_t       dec_mode = MODE_BODY;
	logic [3:0]  dec_nibble = 4'd0;
	logic [11:0] dec_count = 12'd0;
	logic [6:0]  cfg_delim = DELIMITER_RESET;
	logic [11:0] cfg_maxlen = LENGTH_LIMIT_RESET;

	escaped_string_decoder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	function automatic bit hex_nibble_of(input logic [7:0] b, output logic [3:0] nib);
		nib = 4'd0;
		if (b >= "0" && b <= "9") begin
			nib = 4'(b - "0");
		end else if (b >= "A" && b <= "F") begin
			nib = 4'(b - "A" + 8'd10);
		end else if (b >= "a" && b <= "f") begin
			nib = 4'(b - "a" + 8'd10);
		end else begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit control_code_of(input logic [7:0] b, output logic [7:0] code);
		code = 8'h00;
		control_code_of = 1'b1;
		case (b)
			"0": code = 8'h00;
			"a": code = 8'h07;
			"b": code = 8'h08;
			"f": code = 8'h0C;
			"n": code = 8'h0A;
			"r": code = 8'h0D;
			"t": code = 8'h09;
			"v": code = 8'h0B;
			default: control_code_of = 1'b0;
		endcase
	endfunction

	function automatic void restart_literal();
		dec_mode = MODE_BODY;
		dec_nibble = 4'd0;
		dec_count = 12'd0;
	endfunction

	function automatic esd_out_t decode_error(input logic [2:0] code);
		esd_out_t r;
		r = '0;
		r.kind = KIND_ERR;
		r.error_code = code;
		restart_literal();
		return r;
	endfunction

	function automatic esd_out_t decoded_char(input logic [7:0] c);
		esd_out_t r;
		logic [11:0] limit;
		limit = (cfg_maxlen < LENGTH_CAP) ? cfg_maxlen : LENGTH_CAP;
		if (dec_count >= limit) return decode_error(ERR_TOO_LONG);
		r = '0;
		r.kind = KIND_CHAR;
		r.char_value = c;
		dec_count = dec_count + 12'd1;
		dec_mode = MODE_BODY;
		return r;
	endfunction

	// advance the decoder by one item; 1 when the item yields a result
	function automatic bit decode_byte(input esd_in_t it, output esd_out_t r);
		logic [7:0] b;
		logic [7:0] code;
		logic [3:0] nib;
		b = it.in_byte;
		r = '0;
		decode_byte = 1'b1;
		if (it.end_of_input) begin
			case (dec_mode)
				MODE_BODY: r = decode_error(ERR_EOF_BODY);
				MODE_ESC: r = decode_error(ERR_EOF_ESCAPE);
				default: r = decode_error(ERR_EOF_HEX);
			endcase
		end else begin
			case (dec_mode)
				MODE_BODY: begin
					// delimiter wins over backslash
					if (b == {1'b0, cfg_delim}) begin
						r.kind = KIND_END;
						r.literal_length = dec_count;
						restart_literal();
					end else if (b == CHAR_BACKSLASH) begin
						dec_mode = MODE_ESC;
						decode_byte = 1'b0;
					end else begin
						r = decoded_char(b);
					end
				end
				MODE_ESC: begin
					if (b == CHAR_X) begin
						dec_mode = MODE_HEX1;
						decode_byte = 1'b0;
					end else if (b == CHAR_BACKSLASH || b == {1'b0, cfg_delim}) begin
						r = decoded_char(b);
					end else if (control_code_of(b, code)) begin
						r = decoded_char(code);
					end else begin
						r = decode_error(ERR_UNKNOWN);
					end
				end
				MODE_HEX1: begin
					if (hex_nibble_of(b, nib)) begin
						dec_nibble = nib;
						dec_mode = MODE_HEX2;
						decode_byte = 1'b0;
					end else begin
						r = decode_error(ERR_BAD_HEX);
					end
				end
				default: begin
					if (hex_nibble_of(b, nib)) r = decoded_char({dec_nibble, nib});
					else r = decode_error(ERR_BAD_HEX);
				end
			endcase
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict_block
		esd_out_t r;
		if (!arst_n) begin
			restart_literal();
			cfg_delim = DELIMITER_RESET;
			cfg_maxlen = LENGTH_LIMIT_RESET;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_DELIMITER) cfg_delim = cfg_data[6:0];
				else cfg_maxlen = cfg_data;
			end
			if (in_valid && in_ready && decode_byte(in_item, r)) predicted_outputs.push_back(r);
		end
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50) $display("%0t: mismatch: %s", $time, msg);
	endtask

	always @(posedge clk) begin : check_block
		esd_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_outputs.size() == 0) begin
				note_mismatch($sformatf("result %h with nothing pending", out_item));
			end else begin
				want = predicted_outputs.pop_front();
				if (out_item.kind !== want.kind)
					note_mismatch($sformatf("kind %0d, want %0d", out_item.kind, want.kind));
				if (out_item.char_value !== want.char_value)
					note_mismatch($sformatf("char_value %h, want %h",
						out_item.char_value, want.char_value));
				if (out_item.error_code !== want.error_code)
					note_mismatch($sformatf("error_code %0d, want %0d",
						out_item.error_code, want.error_code));
				if (out_item.literal_length !== want.literal_length)
					note_mismatch($sformatf("literal_length %0d, want %0d",
						out_item.literal_length, want.literal_length));
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_item(input logic [7:0] b, input logic eof);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item.in_byte <= b;
		in_item.end_of_input <= eof;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predicted_outputs.size() != 0) @(posedge clk);
		// let a trailing silent item clear the pipeline
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [6:0] delim, input logic [11:0] maxlen);
		cfg_write <= 1'b1;
		cfg_index <= REG_DELIMITER;
		cfg_data <= {5'($urandom), delim};
		@(posedge clk);
		cfg_index <= REG_LENGTH_LIMIT;
		cfg_data <= maxlen;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_idling(input idle_mode_t m);
		send_idle_pct = (m == IDLE_SENDER) ? 85 : (m == IDLE_BOTH) ? 32 : 0;
		stall_pct = (m == IDLE_RECEIVER) ? 85 : (m == IDLE_BOTH) ? 32 : 0;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == {1'b0, cfg_delim} || b == CHAR_BACKSLASH);
		return b;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 4'd10);
	endfunction

	task automatic send_random_literal(input int max_chars);
		int n;
		int pick;
		int k;
		n = $urandom_range(0, max_chars);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_item(plain_byte(), 1'b0);
			end else if (pick < 72) begin
				send_item(CHAR_BACKSLASH, 1'b0);
				k = $urandom_range(0, 9);
				if (k == 0) send_item(CHAR_BACKSLASH, 1'b0);
				else if (k == 1) send_item({1'b0, cfg_delim}, 1'b0);
				else send_item(ESC_LETTERS[8 * $urandom_range(0, 7) +: 8], 1'b0);
			end else if (pick < 90) begin
				send_item(CHAR_BACKSLASH, 1'b0);
				send_item(CHAR_X, 1'b0);
				send_item(hex_char(4'($urandom)), 1'b0);
				send_item(hex_char(4'($urandom)), 1'b0);
			end else begin
				// broken sequences, stray bytes and an early end of input
				case ($urandom_range(0, 4))
					0: send_item(8'($urandom), 1'b0);
					1: begin
						send_item(CHAR_BACKSLASH, 1'b0);
						send_item(8'($urandom), 1'b0);
					end
					2: begin
						send_item(CHAR_BACKSLASH, 1'b0);
						send_item(CHAR_X, 1'b0);
						send_item(8'($urandom), 1'b0);
					end
					3: begin
						send_item(CHAR_BACKSLASH, 1'b0);
						send_item(CHAR_X, 1'b0);
						send_item(hex_char(4'($urandom)), 1'b0);
						send_item(8'($urandom), 1'b0);
					end
					default: send_item(8'($urandom), 1'b1);
				endcase
			end
		end
		pick = $urandom_range(0, 99);
		if (pick < 85) send_item({1'b0, cfg_delim}, 1'b0);
		else if (pick < 92) send_item(8'($urandom), 1'b1);
	endtask

	task automatic test_plain_and_escapes();
		send_text("A");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("\\n\\\"\\\\\\xaF\"");
	endtask

	task automatic test_error_cases();
		send_text("\\q");
		send_text("\\xg");
		send_text("\\x1");
		send_item(8'h00, 1'b0);
		send_text("\\");
		send_item(8'($urandom), 1'b1);
		send_text("\\x");
		send_item(8'($urandom), 1'b1);
		send_text("\\x4");
		send_item(8'($urandom), 1'b1);
		send_item(8'($urandom), 1'b1);
	endtask

	task automatic test_length_limit();
		wait_idle();
		set_config(DELIMITER_RESET, 12'd0);
		send_text("\"a");
		wait_idle();
		set_config(DELIMITER_RESET, 12'd16);
		// fill to the limit and close, then overrun by one
		repeat (16) send_item(plain_byte(), 1'b0);
		send_text("\"");
		repeat (17) send_item(plain_byte(), 1'b0);
		send_text("\"");
	endtask

	task automatic test_random_traffic();
		int phase;
		int start;
		logic [6:0] d;
		logic [11:0] m;
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin d = DELIMITER_RESET; m = LENGTH_LIMIT_RESET; end
				1: begin d = 7'("'"); m = 12'd3; end
				2: begin d = 7'd0; m = 12'd0; end
				3: begin d = 7'd127; m = 12'd1; end
				4: begin d = 7'(CHAR_BACKSLASH); m = 12'd8; end
				5: begin d = 7'(CHAR_X); m = LENGTH_LIMIT_RESET; end
				6: begin d = 7'("n"); m = 12'd2; end
				7: begin d = 7'd32; m = 12'd5; end
				8: begin d = 7'd126; m = 12'($urandom_range(0, 30)); end
				default: begin d = 7'($urandom_range(32, 126)); m = 12'($urandom); end
			endcase
			wait_idle();
			set_config(d, m);
			set_idling(idle_mode_t'(phase % 4));
			start = items_sent;
			while (items_sent - start < 70) send_random_literal((phase == 0) ? 40 : 10);
		end
	endtask

	initial begin : main
		int guard;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_and_escapes();
		test_error_cases();
		test_length_limit();
		test_random_traffic();
		in_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (predicted_outputs.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (predicted_outputs.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", predicted_outputs.size()));
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
